// ===== hw/rtl/wpwl_pkg.sv =====
// Shared types and constants of the write pattern watch logger.
`timescale 1ns / 1ps
package wpwl_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int RING_AW = $clog2(RING_DEPTH);
    localparam logic [28:0] MATCH_MAX = 29'h1FFF_FFFF;
    localparam logic [63:0] PATTERN_RESET = 64'h7e00_7e00_7e00_7e00;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        CFG_ENABLE  = 2'd0,
        CFG_PATTERN = 2'd1,
        CFG_BEGIN   = 2'd2,
        CFG_END     = 2'd3
    } cfg_idx_t;

    // One stored event.
    typedef struct packed {
        logic [63:0] addr;
        logic [31:0] size;
        logic [28:0] match_cnt;
        logic [63:0] first;
        logic        overlap;
        logic [15:0] writer;
        logic [63:0] detail;
        logic [47:0] stamp;
    } event_t;

    // Request from the front part to the back part.
    typedef struct packed {
        logic        is_read;
        logic        is_clear;
        logic [31:0] rd_seq;
        event_t      ev;
    } job_t;

    // Result item.
    typedef struct packed {
        logic [31:0] checked;
        event_t      ev;
        logic [31:0] seq;
        logic        valid;
        logic        kind;
    } result_t;

endpackage

// ===== hw/rtl/wpwl_front.sv =====
// Front part: latches write headers, gathers words and compares them with the pattern.
`timescale 1ns / 1ps
module wpwl_front
    import wpwl_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  command,
    input  logic [63:0] destination,
    input  logic [31:0] write_size,
    input  logic [7:0]  data_byte,
    input  logic        last_beat,
    input  logic [15:0] writer_tag,
    input  logic [63:0] detail,
    input  logic [47:0] timestamp,
    input  logic [31:0] read_sequence,
    input  logic        pattern_enable,
    input  logic [63:0] match_pattern,
    input  logic [63:0] range_begin,
    input  logic [63:0] range_end,
    output logic        job_valid,
    input  logic        job_ready,
    output job_t        job
);

    logic        in_write_reg;
    logic [31:0] offset_reg;
    logic [63:0] shift_reg;
    logic [63:0] addr_reg;
    logic [31:0] size_reg;
    logic [15:0] writer_reg;
    logic [63:0] detail_reg;
    logic [47:0] time_reg;
    logic [28:0] matches_reg;
    logic [63:0] first_reg;
    logic        job_valid_reg;
    job_t        job_reg;

    logic        fire;
    logic [63:0] c_addr;
    logic [31:0] c_size;
    logic [15:0] c_writer;
    logic [63:0] c_detail;
    logic [47:0] c_time;
    logic [31:0] c_off;
    logic [63:0] c_shift;
    logic [28:0] c_matches;
    logic [63:0] c_first;
    logic [2:0]  start;
    logic [31:0] start_w;
    logic [2:0]  pos;
    logic [63:0] shift_next;
    logic [28:0] matches_next;
    logic [63:0] first_next;
    logic        take;
    logic        hit;
    logic [64:0] end_sum;
    logic        overlap;
    job_t        job_next;
    logic        job_emit;

    assign in_ready = !job_valid_reg || job_ready;
    assign fire = in_valid && in_ready;
    assign job_valid = job_valid_reg;
    assign job = job_reg;

    // Current header: fresh on the first beat of a write.
    always_comb
    begin
        if (!in_write_reg)
        begin
            c_addr = destination;
            c_size = write_size;
            c_writer = writer_tag;
            c_detail = detail;
            c_time = timestamp;
            c_off = 32'd0;
            c_shift = 64'd0;
            c_matches = 29'd0;
            c_first = 64'd0;
        end
        else
        begin
            c_addr = addr_reg;
            c_size = size_reg;
            c_writer = writer_reg;
            c_detail = detail_reg;
            c_time = time_reg;
            c_off = offset_reg;
            c_shift = shift_reg;
            c_matches = matches_reg;
            c_first = first_reg;
        end
    end

    // Byte gathering and pattern compare.
    always_comb
    begin
        start = 3'd0 - c_addr[2:0];
        start_w = {29'd0, start};
        pos = c_off[2:0] - start;
        take = (c_off < c_size) && (c_off >= start_w);
        shift_next = c_shift;
        matches_next = c_matches;
        first_next = c_first;
        hit = 1'b0;
        if (take)
        begin
            shift_next = {data_byte, c_shift[63:8]};
            hit = (pos == 3'd7) && pattern_enable && (shift_next == match_pattern);
        end
        if (hit)
        begin
            if (c_matches == 29'd0)
            begin
                first_next = c_addr + {32'd0, c_off - 32'd7};
            end
            if (c_matches != MATCH_MAX)
            begin
                matches_next = c_matches + 29'd1;
            end
        end
    end

    // Watch range overlap, with the end address taken modulo 2^64.
    always_comb
    begin
        end_sum = {1'b0, c_addr} + {33'd0, c_size};
        overlap = (range_begin < range_end) && (c_addr < range_end)
                  && (end_sum[63:0] > range_begin);
    end

    // Request for the back part.
    always_comb
    begin
        job_next.is_read = 1'b0;
        job_next.is_clear = 1'b0;
        job_next.rd_seq = read_sequence;
        job_next.ev.addr = c_addr;
        job_next.ev.size = c_size;
        job_next.ev.match_cnt = matches_next;
        job_next.ev.first = first_next;
        job_next.ev.overlap = overlap;
        job_next.ev.writer = c_writer;
        job_next.ev.detail = c_detail;
        job_next.ev.stamp = c_time;
        job_emit = 1'b0;
        unique case (cmd_t'(command))
            CMD_READ:
            begin
                job_next.is_read = 1'b1;
                job_emit = 1'b1;
            end
            CMD_CLEAR:
            begin
                job_next.is_clear = 1'b1;
                job_emit = 1'b1;
            end
            CMD_WRITE:
            begin
                job_emit = last_beat && (c_size != 32'd0);
            end
            default:
            begin
                job_emit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_write_reg <= 1'b0;
            job_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                job_valid_reg <= job_emit;
            end
            else if (job_ready)
            begin
                job_valid_reg <= 1'b0;
            end
            if (fire && (cmd_t'(command) == CMD_WRITE))
            begin
                in_write_reg <= !last_beat;
            end
        end
    end

    // Write context and request payload.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            job_reg <= job_next;
            if (cmd_t'(command) == CMD_WRITE)
            begin
                addr_reg <= c_addr;
                size_reg <= c_size;
                writer_reg <= c_writer;
                detail_reg <= c_detail;
                time_reg <= c_time;
                offset_reg <= (c_off == 32'hFFFF_FFFF) ? c_off : c_off + 32'd1;
                shift_reg <= shift_next;
                matches_reg <= matches_next;
                first_reg <= first_next;
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_no_job_on_ignored: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_t'(command) == CMD_NONE) |=> !job_valid)
        else $error("job raised for unused command");
    a_hold_job: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid && !job_ready) |=> job_valid && $stable(job))
        else $error("pending job changed");
    a_zero_size_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && cmd_t'(command) == CMD_WRITE && last_beat && c_size == 32'd0)
        |=> !job_valid)
        else $error("zero size write reported");
`endif

endmodule

// ===== hw/rtl/wpwl_back.sv =====
// Back part: event ring, sequence and write counters, result register.
`timescale 1ns / 1ps
module wpwl_back
    import wpwl_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          job_valid,
    output logic          job_ready,
    input  job_t          job,
    output logic          res_valid,
    input  logic          res_ready,
    output result_t       res
);

    event_t        ring_mem [RING_DEPTH];
    logic [31:0]   seq_ctr_reg;
    logic [31:0]   checked_reg;
    logic          res_valid_reg;
    logic          kind_reg;
    logic          valid_reg;
    logic [31:0]   seq_reg;
    event_t        wev_reg;
    event_t        rd_data_reg;
    logic [31:0]   checked_out_reg;

    logic          fire;
    logic          logged;
    logic          held;
    logic [31:0]   seq_gap;
    logic [32:0]   depth_w;
    logic [31:0]   checked_next;

    assign job_ready = !res_valid_reg || res_ready;
    assign fire = job_valid && job_ready;
    assign logged = (job.ev.match_cnt != 29'd0) || job.ev.overlap;
    assign seq_gap = seq_ctr_reg - job.rd_seq;
    assign depth_w = 33'(RING_DEPTH);
    assign held = (job.rd_seq < seq_ctr_reg) && ({1'b0, seq_gap} <= depth_w);
    assign checked_next = (checked_reg == 32'hFFFF_FFFF) ? checked_reg
                                                         : checked_reg + 32'd1;

    // Counters and result handshake.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_ctr_reg <= 32'd0;
            checked_reg <= 32'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                res_valid_reg <= !job.is_clear;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (fire)
            begin
                priority if (job.is_clear)
                begin
                    seq_ctr_reg <= 32'd0;
                    checked_reg <= 32'd0;
                end
                else if (!job.is_read)
                begin
                    checked_reg <= checked_next;
                    if (logged)
                    begin
                        seq_ctr_reg <= seq_ctr_reg + 32'd1;
                    end
                end
            end
        end
    end

    // Ring memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (fire && !job.is_clear && !job.is_read && logged)
        begin
            ring_mem[seq_ctr_reg[RING_AW-1:0]] <= job.ev;
        end
        if (fire && job.is_read)
        begin
            rd_data_reg <= ring_mem[job.rd_seq[RING_AW-1:0]];
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (fire && !job.is_clear)
        begin
            kind_reg <= job.is_read;
            if (job.is_read)
            begin
                valid_reg <= held;
                seq_reg <= job.rd_seq;
                checked_out_reg <= checked_reg;
            end
            else
            begin
                valid_reg <= logged;
                seq_reg <= logged ? seq_ctr_reg : 32'd0;
                checked_out_reg <= checked_next;
                wev_reg <= job.ev;
            end
        end
    end

    always_comb
    begin
        res.kind = kind_reg;
        res.valid = valid_reg;
        res.seq = seq_reg;
        res.checked = checked_out_reg;
        if (!kind_reg)
        begin
            res.ev = wev_reg;
        end
        else if (valid_reg)
        begin
            res.ev = rd_data_reg;
        end
        else
        begin
            res.ev = '0;
        end
    end

    assign res_valid = res_valid_reg;

`ifndef NO_ASSERTIONS
    a_clear_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && job.is_clear) |=> !res_valid)
        else $error("clear produced a result");
    a_seq_step: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && !job.is_clear && !job.is_read && logged)
        |=> seq_ctr_reg == $past(seq_ctr_reg) + 32'd1)
        else $error("sequence did not advance");
    a_read_keeps_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && job.is_read) |=> $stable(seq_ctr_reg) && $stable(checked_reg))
        else $error("read changed counters");
`endif

endmodule

// ===== hw/rtl/write_pattern_watch_logger.sv =====
// Top level of the write pattern watch logger.
`timescale 1ns / 1ps
// Usage:
// s_axis carries one request per beat: a write data byte, a readback of a
// logged event by sequence number, or a counter clear (command in tuser).
// Write headers are taken from the first byte beat; tlast marks the final one.
// m_axis returns one result for each nonzero-size finished write and for each
// readback; clears and unused commands give none.
// Throughput is one request per cycle while m_axis does not stall. An accepted
// request is registered first in the front part (byte gathering, pattern
// compare, overlap check), then in the back part (ring access, counters).
// The event ring is a 4096-entry memory with one write and one registered
// read port; entries never written read as undefined.
// Reset clears the counters, the write context and both handshake stages;
// configuration returns to its reset values. If the receiver stalls, the
// result register holds, the back part stops, and the front part keeps one
// request waiting before s_axis_tready drops.
// Configuration writes take effect the next cycle; the user must make them while idle (not enforced by the block).
module write_pattern_watch_logger
    import wpwl_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    input  logic         s_axis_tlast,
    // destination[63:0], write_size[95:64], data_byte[103:96], writer_tag[119:104],
    // detail[183:120], timestamp[231:184], read_sequence[263:232], zero[271:264]
    input  logic [271:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_kind[0]
    output logic         m_axis_tuser,
    // event_valid[0], sequence_res[32:1], event_address[96:33], event_size[128:97],
    // match_count[157:129], first_match_address[221:158], overlaps_range[222],
    // event_writer[238:223], event_detail[302:239], event_time[350:303],
    // writes_checked[382:351], zero[383]
    output logic [383:0] m_axis_tdata,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [63:0]  cfg_data
);

    logic        enable_reg;
    logic [63:0] pattern_reg;
    logic [63:0] begin_reg;
    logic [63:0] end_reg;
    logic        job_valid;
    logic        job_ready;
    job_t        job;
    result_t     res;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            pattern_reg <= PATTERN_RESET;
            begin_reg <= 64'd0;
            end_reg <= 64'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ENABLE:  enable_reg <= cfg_data[0];
                CFG_PATTERN: pattern_reg <= cfg_data;
                CFG_BEGIN:   begin_reg <= cfg_data;
                CFG_END:     end_reg <= cfg_data;
                default:     enable_reg <= enable_reg;
            endcase
        end
    end

    wpwl_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_axis_tvalid),
        .in_ready       (s_axis_tready),
        .command        (s_axis_tuser),
        .destination    (s_axis_tdata[63:0]),
        .write_size     (s_axis_tdata[95:64]),
        .data_byte      (s_axis_tdata[103:96]),
        .last_beat      (s_axis_tlast),
        .writer_tag     (s_axis_tdata[119:104]),
        .detail         (s_axis_tdata[183:120]),
        .timestamp      (s_axis_tdata[231:184]),
        .read_sequence  (s_axis_tdata[263:232]),
        .pattern_enable (enable_reg),
        .match_pattern  (pattern_reg),
        .range_begin    (begin_reg),
        .range_end      (end_reg),
        .job_valid      (job_valid),
        .job_ready      (job_ready),
        .job            (job)
    );

    wpwl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res       (res)
    );

    assign m_axis_tuser = res.kind;
    assign m_axis_tdata = {1'b0, res.checked, res.ev.stamp, res.ev.detail, res.ev.writer,
                           res.ev.overlap, res.ev.first, res.ev.match_cnt, res.ev.size,
                           res.ev.addr, res.seq, res.valid};

endmodule
